// ===== rtl/lie_pkg.sv =====
// ----------------------------------------------------------------------------
// lie_pkg
// Shared types and constants for the indexed list. This covers the operation
// codes, sequencer states, store control, stream field layout and defaults.
// ----------------------------------------------------------------------------
package lie_pkg;

   // Default sizing
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Field widths on the streams
   localparam int OPCODE_W    = 4;
   localparam int POSITION_W  = 5;
   localparam int VALUE_W     = 32;
   localparam int NEW_COUNT_W = 5;
   localparam int STATUS_W    = 1;
   localparam int COUNT_W     = 5;

   // Request tdata layout, from the lowest bit up
   localparam int REQ_OPCODE_LSB    = 0;
   localparam int REQ_POSITION_LSB  = REQ_OPCODE_LSB + OPCODE_W;
   localparam int REQ_VALUE_LSB     = REQ_POSITION_LSB + POSITION_W;
   localparam int REQ_NEW_COUNT_LSB = REQ_VALUE_LSB + VALUE_W;
   localparam int REQ_USED_W        = REQ_NEW_COUNT_LSB + NEW_COUNT_W;
   localparam int REQ_TDATA_W       = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout, from the lowest bit up
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_VALUE_LSB  = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_COUNT_LSB  = RSP_VALUE_LSB + VALUE_W;
   localparam int RSP_EMPTY_LSB  = RSP_COUNT_LSB + COUNT_W;
   localparam int RSP_USED_W     = RSP_EMPTY_LSB + 1;
   localparam int RSP_TDATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   // Status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Operation codes
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_BACK  = 4'd0,
      OP_PUSH_FRONT = 4'd1,
      OP_INSERT     = 4'd2,
      OP_ASSIGN     = 4'd3,
      OP_POP_BACK   = 4'd4,
      OP_POP_FRONT  = 4'd5,
      OP_ERASE      = 4'd6,
      OP_CLEAR      = 4'd7,
      OP_GET        = 4'd8,
      OP_RESIZE     = 4'd9
   } lie_op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINAL_WR,
      ST_GET_RD,
      ST_GET_DATA,
      ST_RESP
   } lie_state_type;

   // Store port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } lie_mem_ctl_type;

endpackage

// ===== rtl/indexed_list_insert_erase.sv =====
// Request transfer to rsp_tvalid: pop back, clear, resize and refused requests
// go straight to the response; assign writes (FINAL_WR), get reads (GET_RD,
// GET_DATA); insert and erase move entries by read and write states (SHIFT_RD,
// SHIFT_WR), insert then writes the new entry. Throughput: one operation at a
// time; the next request is taken the cycle after the response transfer.
// Reset: synchronous; count zero and every entry reads zero until written.
// ----------------------------------------------------------------------------
// indexed_list_insert_erase
// Fixed-capacity ordered list with push, pop, insert, erase, assign, get,
// clear and resize, on a request and a response stream.
// ----------------------------------------------------------------------------
module indexed_list_insert_erase
   import lie_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // opcode[3:0], position[8:4], value[40:9], new_count[45:41], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[0], read_value[32:1], count[37:33], empty_res[38], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(DEPTH);

   lie_mem_ctl_type       mem_ctl;
   logic [AW-1:0]         mem_waddr;
   logic [AW-1:0]         mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic [DATA_WIDTH-1:0] mem_rdata;
   logic                  res_status;
   logic [VALUE_W-1:0]    res_read_value;
   logic [COUNT_W-1:0]    res_count;
   logic                  res_empty;

   lie_seq #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .op_opcode      (req_tdata[REQ_OPCODE_LSB +: OPCODE_W]),
      .op_position    (req_tdata[REQ_POSITION_LSB +: POSITION_W]),
      .op_value       (req_tdata[REQ_VALUE_LSB +: VALUE_W]),
      .op_new_count   (req_tdata[REQ_NEW_COUNT_LSB +: NEW_COUNT_W]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .res_status     (res_status),
      .res_read_value (res_read_value),
      .res_count      (res_count),
      .res_empty      (res_empty),
      .mem_ctl        (mem_ctl),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   lie_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .ctl   (mem_ctl),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Response packing
   always_comb begin
      rsp_tdata                                 = '0;
      rsp_tdata[RSP_STATUS_LSB]                 = res_status;
      rsp_tdata[RSP_VALUE_LSB +: VALUE_W]       = res_read_value;
      rsp_tdata[RSP_COUNT_LSB +: COUNT_W]       = res_count;
      rsp_tdata[RSP_EMPTY_LSB]                  = res_empty;
   end

endmodule

// ===== rtl/lie_store.sv =====
// ----------------------------------------------------------------------------
// lie_store
// Entry store: one write port, one registered read port. A valid bit per
// entry, cleared by reset, makes a never-written entry read as zero.
// ----------------------------------------------------------------------------
module lie_store
   import lie_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lie_mem_ctl_type              ctl,
   input  logic [$clog2(DEPTH)-1:0]     waddr,
   input  logic [DATA_WIDTH-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0]     raddr,
   output logic [DATA_WIDTH-1:0]        rdata
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [DATA_WIDTH-1:0] rd_word_ff;
   logic                  rd_valid_ff;

   // Word array, write and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[waddr] <= wdata;
      end
      if (ctl.rd_en) begin
         rd_word_ff <= mem[raddr];
      end
   end

   // Valid bits and the registered valid of the read
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[waddr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[raddr];
         end
      end
   end

   // Unwritten entries read as zero
   assign rdata = rd_valid_ff ? rd_word_ff : '0;

endmodule

// ===== rtl/lie_seq.sv =====
// ----------------------------------------------------------------------------
// lie_seq
// Operation sequencer. Checks each request, keeps the entry count and moves
// entries one at a time through the store with a shared cursor stepper.
// ----------------------------------------------------------------------------
module lie_seq
   import lie_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [OPCODE_W-1:0]          op_opcode,
   input  logic [POSITION_W-1:0]        op_position,
   input  logic [VALUE_W-1:0]           op_value,
   input  logic [NEW_COUNT_W-1:0]       op_new_count,
   // response side
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         res_status,
   output logic [VALUE_W-1:0]           res_read_value,
   output logic [COUNT_W-1:0]           res_count,
   output logic                         res_empty,
   // store port
   output lie_mem_ctl_type              mem_ctl,
   output logic [$clog2(DEPTH)-1:0]     mem_waddr,
   output logic [DATA_WIDTH-1:0]        mem_wdata,
   output logic [$clog2(DEPTH)-1:0]     mem_raddr,
   input  logic [DATA_WIDTH-1:0]        mem_rdata
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int MAXW  = (CW > POSITION_W) ? CW : POSITION_W;
   localparam int CMPW  = MAXW + 1;

   lie_state_type         state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         cursor_ff, cursor_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic                  ins_ff, ins_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [DATA_WIDTH-1:0] rd_ff, rd_in;
   logic                  status_ff, status_in;

   logic                  accept;
   logic [CMPW-1:0]       pos_x, cnt_x, depth_x, nc_x, ins_pos_x, era_pos_x;
   logic                  full;
   logic [AW-1:0]         step;
   logic                  more;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   // Operands widened for the range checks
   assign pos_x   = CMPW'(op_position);
   assign cnt_x   = CMPW'(count_ff);
   assign depth_x = CMPW'(DEPTH);
   assign nc_x    = CMPW'(op_new_count);
   assign full    = (cnt_x == depth_x);

   // Shared cursor stepper: down while opening a gap, up while closing one
   assign step = cursor_ff + (ins_ff ? {AW{1'b1}} : AW'(1));
   assign more = ins_ff ? (cursor_ff > pos_ff) : (CW'(cursor_ff) < count_ff);

   always_comb begin
      ins_pos_x = pos_x;
      era_pos_x = pos_x;
      if (lie_op_type'(op_opcode) == OP_PUSH_BACK) begin
         ins_pos_x = cnt_x;
      end else if (lie_op_type'(op_opcode) == OP_PUSH_FRONT) begin
         ins_pos_x = '0;
      end
      if (lie_op_type'(op_opcode) == OP_POP_FRONT) begin
         era_pos_x = '0;
      end
   end

   // Next state and store strobes
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      pos_in    = pos_ff;
      ins_in    = ins_ff;
      word_in   = word_ff;
      rd_in     = rd_ff;
      status_in = status_ff;
      mem_ctl   = '0;
      mem_waddr = cursor_ff;
      mem_wdata = mem_rdata;
      mem_raddr = step;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               word_in   = DATA_WIDTH'(op_value);
               rd_in     = '0;
               status_in = STATUS_ERR;
               state_in  = ST_RESP;
               case (op_opcode) inside
                  OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
                     if (!full && ins_pos_x <= cnt_x) begin
                        status_in = STATUS_OK;
                        ins_in    = 1'b1;
                        pos_in    = AW'(ins_pos_x);
                        cursor_in = AW'(count_ff);
                        count_in  = count_ff + CW'(1);
                        state_in  = ST_SHIFT_RD;
                     end
                  end
                  OP_ASSIGN: begin
                     if (pos_x < cnt_x) begin
                        status_in = STATUS_OK;
                        pos_in    = AW'(pos_x);
                        state_in  = ST_FINAL_WR;
                     end
                  end
                  OP_POP_BACK: begin
                     if (count_ff != '0) begin
                        status_in = STATUS_OK;
                        count_in  = count_ff - CW'(1);
                     end
                  end
                  OP_POP_FRONT, OP_ERASE: begin
                     if (era_pos_x < cnt_x) begin
                        status_in = STATUS_OK;
                        ins_in    = 1'b0;
                        cursor_in = AW'(era_pos_x);
                        count_in  = count_ff - CW'(1);
                        state_in  = ST_SHIFT_RD;
                     end
                  end
                  OP_CLEAR: begin
                     status_in = STATUS_OK;
                     count_in  = '0;
                  end
                  OP_GET: begin
                     if (pos_x < cnt_x) begin
                        status_in = STATUS_OK;
                        pos_in    = AW'(pos_x);
                        state_in  = ST_GET_RD;
                     end
                  end
                  OP_RESIZE: begin
                     if (nc_x <= depth_x) begin
                        status_in = STATUS_OK;
                        count_in  = CW'(nc_x);
                     end
                  end
                  default: begin
                     status_in = STATUS_ERR;
                  end
               endcase
            end
         end
         ST_SHIFT_RD: begin
            if (more) begin
               mem_ctl.rd_en = 1'b1;
               state_in      = ST_SHIFT_WR;
            end else begin
               state_in = ins_ff ? ST_FINAL_WR : ST_RESP;
            end
         end
         ST_SHIFT_WR: begin
            mem_ctl.wr_en = 1'b1;
            cursor_in     = step;
            state_in      = ST_SHIFT_RD;
         end
         ST_FINAL_WR: begin
            mem_ctl.wr_en = 1'b1;
            mem_waddr     = pos_ff;
            mem_wdata     = word_ff;
            state_in      = ST_RESP;
         end
         ST_GET_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_raddr     = pos_ff;
            state_in      = ST_GET_DATA;
         end
         ST_GET_DATA: begin
            rd_in    = mem_rdata;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Operand and result registers
   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      pos_ff    <= pos_in;
      ins_ff    <= ins_in;
      word_ff   <= word_in;
      rd_ff     <= rd_in;
      status_ff <= status_in;
   end

   assign res_status     = status_ff;
   assign res_read_value = VALUE_W'(rd_ff);
   assign res_count      = COUNT_W'(count_ff);
   assign res_empty      = (count_ff == '0);

endmodule

// ===== rtl/lie_checker.sv =====
// ----------------------------------------------------------------------------
// lie_checker
// Port-level checks on the indexed list: one operation in flight, response
// fields consistent, held responses stable, clear answers at once.
// ----------------------------------------------------------------------------
module lie_checker
   import lie_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // No request taken while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while a response is pending");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Empty flag follows the count
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_EMPTY_LSB] ==
                     (rsp_tdata[RSP_COUNT_LSB +: COUNT_W] == '0))
      else $error("empty flag disagrees with count");

   // A failed operation reads zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_STATUS_LSB] == STATUS_ERR |->
         rsp_tdata[RSP_VALUE_LSB +: VALUE_W] == '0)
      else $error("error response carries a read word");

   // Clear answers in the next cycle with an empty list
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      req_tdata[REQ_OPCODE_LSB +: OPCODE_W] == OP_CLEAR |=>
         rsp_tvalid && rsp_tdata[RSP_EMPTY_LSB] &&
         rsp_tdata[RSP_STATUS_LSB] == STATUS_OK)
      else $error("clear did not empty the list");

endmodule

bind indexed_list_insert_erase lie_checker u_lie_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
